// ----- hdl/fpp_pkg.sv -----
package fpp_pkg;

   // Fixed-point layout
   localparam int FREQ_W      = 20;   // open frequencies, Hz with 8 fractional bits
   localparam int PITCH_W     = 22;   // result frequency, Hz with 8 fractional bits
   localparam int NECK_W      = 10;   // neck length in whole millimetres
   localparam int FRAC_BITS   = 16;   // fractional bits of the ratio
   localparam int RAD_FRAC_W  = 2 * FRAC_BITS;        // quotient scaled by 2^32
   localparam int QUOT_HEAD_W = 4;                    // quotient stays below 10 * 2^32
   localparam int QUOT_W      = RAD_FRAC_W + QUOT_HEAD_W;
   localparam int ROOT_W      = QUOT_W / 2;
   localparam int PROD_W      = FREQ_W + ROOT_W;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES  = QUOT_W / STEPS_PER_STAGE;
   localparam int SQRT_STAGES = ROOT_W / STEPS_PER_STAGE;

   // Clamp term floor(len * 2^16 / 30) as floor(len * RECIP / 2^14)
   localparam int CLAMP_W      = 22;
   localparam int CLAMP_RECIP_W = 26;
   localparam logic [CLAMP_RECIP_W-1:0] CLAMP_RECIP = 26'd35791395;
   localparam int CLAMP_SHIFT  = 14;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NECK_LEN   = 3'd0,
      CSR_OPEN_FREQ0 = 3'd1,
      CSR_OPEN_FREQ1 = 3'd2,
      CSR_OPEN_FREQ2 = 3'd3,
      CSR_OPEN_FREQ3 = 3'd4
   } csr_index_type;

   localparam logic [NECK_W-1:0] NECK_LEN_RESET  = 10'd330;
   localparam logic [FREQ_W-1:0] OPEN_FREQ0_RESET = 20'd33536;
   localparam logic [FREQ_W-1:0] OPEN_FREQ1_RESET = 20'd50176;
   localparam logic [FREQ_W-1:0] OPEN_FREQ2_RESET = 20'd75008;
   localparam logic [FREQ_W-1:0] OPEN_FREQ3_RESET = 20'd112640;

   // Sideband that travels with each word down the pipeline
   typedef struct packed {
      logic       valid;
      logic [1:0] string_number;
      logic       open_tail;
      logic       in_range;
   } stage_tag_type;

   function automatic logic [FREQ_W-1:0] open_freq_reset(input logic [2:0] entry);
      logic [FREQ_W-1:0] value;
      case (entry)
         3'd0:    value = OPEN_FREQ0_RESET;
         3'd1:    value = OPEN_FREQ1_RESET;
         3'd2:    value = OPEN_FREQ2_RESET;
         3'd3:    value = OPEN_FREQ3_RESET;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

// ----- hdl/fpp_freq_mem.sv -----
module fpp_freq_mem
   import fpp_pkg::*;
#(
   parameter int DEPTH  = 4,
   parameter int ADDR_W = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [FREQ_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [FREQ_W-1:0] rd_data
);

   logic [FREQ_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  written_ff;
   logic [FREQ_W-1:0] data_ff;
   logic [FREQ_W-1:0] init_ff;
   logic              hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Mark entries that hold a written value; others read as their reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= mem[rd_addr];
         hit_ff  <= written_ff[rd_addr];
         init_ff <= open_freq_reset(3'(rd_addr));
      end
   end

   assign rd_data = hit_ff ? data_ff : init_ff;

endmodule

// ----- hdl/fpp_div.sv -----
module fpp_div
   import fpp_pkg::*;
#(
   parameter int SENSOR_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  stage_tag_type          in_tag,
   input  logic [SENSOR_BITS-1:0] in_divisor,
   output stage_tag_type          out_tag,
   output logic [QUOT_W-1:0]      out_quotient
);

   localparam logic [SENSOR_BITS-1:0] FULL_SCALE = {SENSOR_BITS{1'b1}};
   // Dividend is FULL_SCALE * 2^32: the high part seeds the remainder
   localparam logic [SENSOR_BITS-1:0] REM_INIT = FULL_SCALE >> QUOT_HEAD_W;
   localparam logic [QUOT_W-1:0] DIVIDEND_LOW =
      {FULL_SCALE[QUOT_HEAD_W-1:0], {RAD_FRAC_W{1'b0}}};

   stage_tag_type          tag_ff  [DIV_STAGES];
   logic [SENSOR_BITS-1:0] rem_ff  [DIV_STAGES];
   logic [SENSOR_BITS-1:0] dvsr_ff [DIV_STAGES];
   logic [QUOT_W-1:0]      quot_ff [DIV_STAGES];

   stage_tag_type          src_tag  [DIV_STAGES];
   logic [SENSOR_BITS-1:0] src_rem  [DIV_STAGES];
   logic [SENSOR_BITS-1:0] src_dvsr [DIV_STAGES];
   logic [QUOT_W-1:0]      src_quot [DIV_STAGES];
   logic [SENSOR_BITS-1:0] rem_in   [DIV_STAGES];
   logic [QUOT_W-1:0]      quot_in  [DIV_STAGES];

   always_comb begin
      src_tag[0]  = in_tag;
      src_rem[0]  = REM_INIT;
      src_dvsr[0] = in_divisor;
      src_quot[0] = '0;
      for (int s = 1; s < DIV_STAGES; s++) begin
         src_tag[s]  = tag_ff[s-1];
         src_rem[s]  = rem_ff[s-1];
         src_dvsr[s] = dvsr_ff[s-1];
         src_quot[s] = quot_ff[s-1];
      end
   end

   // Two restoring steps per stage, one quotient bit each
   always_comb begin
      logic [SENSOR_BITS:0]   trial;
      logic [SENSOR_BITS-1:0] rem_w;
      logic [QUOT_W-1:0]      quot_w;
      for (int s = 0; s < DIV_STAGES; s++) begin
         rem_w  = src_rem[s];
         quot_w = src_quot[s];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            trial = {rem_w, DIVIDEND_LOW[QUOT_W - 1 - (STEPS_PER_STAGE * s + j)]};
            if (trial >= {1'b0, src_dvsr[s]}) begin
               rem_w  = SENSOR_BITS'(trial - {1'b0, src_dvsr[s]});
               quot_w = {quot_w[QUOT_W-2:0], 1'b1};
            end else begin
               rem_w  = trial[SENSOR_BITS-1:0];
               quot_w = {quot_w[QUOT_W-2:0], 1'b0};
            end
         end
         rem_in[s]  = rem_w;
         quot_in[s] = quot_w;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (reset) begin
            tag_ff[s] <= '0;
         end else if (advance) begin
            tag_ff[s] <= src_tag[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            rem_ff[s]  <= rem_in[s];
            dvsr_ff[s] <= src_dvsr[s];
            quot_ff[s] <= quot_in[s];
         end
      end
   end

   assign out_tag      = tag_ff[DIV_STAGES-1];
   assign out_quotient = quot_ff[DIV_STAGES-1];

endmodule

// ----- hdl/fpp_sqrt.sv -----
module fpp_sqrt
   import fpp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  stage_tag_type     in_tag,
   input  logic [QUOT_W-1:0] in_radicand,
   output stage_tag_type     out_tag,
   output logic [ROOT_W-1:0] out_root
);

   localparam int REM_W = ROOT_W + 2;

   stage_tag_type     tag_ff  [SQRT_STAGES];
   logic [QUOT_W-1:0] rad_ff  [SQRT_STAGES];
   logic [REM_W-1:0]  rem_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff [SQRT_STAGES];

   stage_tag_type     src_tag  [SQRT_STAGES];
   logic [QUOT_W-1:0] src_rad  [SQRT_STAGES];
   logic [REM_W-1:0]  src_rem  [SQRT_STAGES];
   logic [ROOT_W-1:0] src_root [SQRT_STAGES];
   logic [REM_W-1:0]  rem_in   [SQRT_STAGES];
   logic [ROOT_W-1:0] root_in  [SQRT_STAGES];

   always_comb begin
      src_tag[0]  = in_tag;
      src_rad[0]  = in_radicand;
      src_rem[0]  = '0;
      src_root[0] = '0;
      for (int s = 1; s < SQRT_STAGES; s++) begin
         src_tag[s]  = tag_ff[s-1];
         src_rad[s]  = rad_ff[s-1];
         src_rem[s]  = rem_ff[s-1];
         src_root[s] = root_ff[s-1];
      end
   end

   // Digit-by-digit root: bring down two radicand bits, try (root << 2) | 1
   always_comb begin
      logic [REM_W+1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_w;
      logic [ROOT_W-1:0] root_w;
      for (int s = 0; s < SQRT_STAGES; s++) begin
         rem_w  = src_rem[s];
         root_w = src_root[s];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            rem_sh = {rem_w,
                      src_rad[s][2 * (ROOT_W - 1 - (STEPS_PER_STAGE * s + j)) +: 2]};
            trial  = {root_w, 2'b01};
            if (rem_sh >= (REM_W + 2)'(trial)) begin
               rem_w  = REM_W'(rem_sh - (REM_W + 2)'(trial));
               root_w = {root_w[ROOT_W-2:0], 1'b1};
            end else begin
               rem_w  = REM_W'(rem_sh);
               root_w = {root_w[ROOT_W-2:0], 1'b0};
            end
         end
         rem_in[s]  = rem_w;
         root_in[s] = root_w;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
         if (reset) begin
            tag_ff[s] <= '0;
         end else if (advance) begin
            tag_ff[s] <= src_tag[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < SQRT_STAGES; s++) begin
            rad_ff[s]  <= src_rad[s];
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
         end
      end
   end

   assign out_tag  = tag_ff[SQRT_STAGES-1];
   assign out_root = root_ff[SQRT_STAGES-1];

endmodule

// ----- hdl/fingerboard_position_to_pitch_core.sv -----
// Fingerboard position to pitch.
// Request channel (req_valid/req_ready): one word per string reading, carrying
// the string number and the raw sensor reading. Response channel
// (rsp_valid/rsp_ready): one word per request, in order, with the pitch in Hz
// (8 fractional bits), the echoed string number and an open-string flag.
// Configuration channel (csr_valid/csr_ready): csr_index 0 writes the neck
// length, 1 to 4 write the open frequencies of strings 0 to 3; csr_ready is
// always high, and writes are meant for when no word is in flight.
// From request accept to response valid a word passes one input
// stage, 18 divider stages (FULL_SCALE * 2^32 / reading, two quotient bits a
// stage), 9 square-root stages (two root bits a stage), the ratio stage
// (alongside the open-frequency memory read), the multiply stage and the
// output register.
// Throughput is one word per cycle: every stage takes a new word each cycle.
// The whole pipeline holds while a response waits unaccepted; req_ready is low
// only then. Reset empties the pipeline and restores the neck length and open
// frequencies to their defaults; no clearing pass is needed.
module fingerboard_position_to_pitch_core
   import fpp_pkg::*;
#(
   parameter int STRING_COUNT = 4,
   parameter int SENSOR_BITS  = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_string_number,
   input  logic [15:0]            req_sensor_reading,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PITCH_W-1:0]     rsp_pitch_hz,
   output logic [1:0]             rsp_string_tag,
   output logic                   rsp_open_string,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int ADDR_W = (STRING_COUNT > 1) ? $clog2(STRING_COUNT) : 1;
   localparam logic [SENSOR_BITS-1:0] FULL_SCALE = {SENSOR_BITS{1'b1}};
   // Readings at or below a tenth of full scale count as the open string
   localparam logic [SENSOR_BITS-1:0] OPEN_TAIL_LIMIT =
      SENSOR_BITS'((int'(FULL_SCALE) * 20) / 200);

   // ---------------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------------
   logic                 wr_neck;
   logic                 wr_freq;
   logic [2:0]           freq_entry;
   logic                 freq_wr_en;
   logic [NECK_W-1:0]    neck_len_ff;
   logic [CLAMP_W-1:0]   clamp_ff;
   logic [CLAMP_W-1:0]   clamp_in;
   logic [NECK_W+CLAMP_RECIP_W-1:0] clamp_prod;

   assign csr_ready = 1'b1;

   always_comb begin
      wr_neck = 1'b0;
      wr_freq = 1'b0;
      unique case (csr_index) inside
         CSR_NECK_LEN: wr_neck = csr_valid;
         CSR_OPEN_FREQ0, CSR_OPEN_FREQ1, CSR_OPEN_FREQ2, CSR_OPEN_FREQ3:
            wr_freq = csr_valid;
         default: ;   // drop writes beyond the register list
      endcase
   end

   assign freq_entry = 3'(csr_index - CSR_OPEN_FREQ0);
   assign freq_wr_en = wr_freq && (int'(freq_entry) < STRING_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         neck_len_ff <= NECK_LEN_RESET;
      end else if (wr_neck) begin
         neck_len_ff <= csr_data[NECK_W-1:0];
      end
   end

   // Clamp term, refreshed every cycle from the neck length: len * 2^16 / 30
   // by reciprocal multiply, exact over the whole 10-bit range
   assign clamp_prod = (NECK_W + CLAMP_RECIP_W)'(neck_len_ff) *
                       (NECK_W + CLAMP_RECIP_W)'(CLAMP_RECIP);
   assign clamp_in   = CLAMP_W'(clamp_prod >> CLAMP_SHIFT);

   always_ff @(posedge clock) begin
      clamp_ff <= clamp_in;
   end

   // ---------------------------------------------------------------------
   // Pipeline control: every stage advances unless the response is stuck
   // ---------------------------------------------------------------------
   logic                   advance;
   logic                   rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Input stage: saturate the reading and classify it
   logic [SENSOR_BITS-1:0] reading_sat;
   stage_tag_type          in_tag_in;
   stage_tag_type          in_tag_ff;
   logic [SENSOR_BITS-1:0] reading_ff;

   assign reading_sat = (req_sensor_reading > 16'(FULL_SCALE)) ? FULL_SCALE
                                                                : req_sensor_reading[SENSOR_BITS-1:0];

   always_comb begin
      in_tag_in.valid         = req_valid;
      in_tag_in.string_number = req_string_number;
      in_tag_in.open_tail     = (reading_sat <= OPEN_TAIL_LIMIT);
      in_tag_in.in_range      = (int'(req_string_number) < STRING_COUNT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_tag_ff <= '0;
      end else if (advance) begin
         in_tag_ff <= in_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         reading_ff <= reading_sat;
      end
   end

   // Quotient FULL_SCALE * 2^32 / reading (meaningless in the open tail,
   // where the result ignores it)
   stage_tag_type       div_tag;
   logic [QUOT_W-1:0]   div_quot;

   fpp_div #(
      .SENSOR_BITS(SENSOR_BITS)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_tag      (in_tag_ff),
      .in_divisor  (reading_ff),
      .out_tag     (div_tag),
      .out_quotient(div_quot)
   );

   stage_tag_type       sqrt_tag;
   logic [ROOT_W-1:0]   sqrt_root;

   fpp_sqrt u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_tag     (div_tag),
      .in_radicand(div_quot),
      .out_tag    (sqrt_tag),
      .out_root   (sqrt_root)
   );

   // Ratio stage: take the smaller of root and clamp, read the open frequency
   stage_tag_type       ratio_tag_ff;
   logic [ROOT_W-1:0]   ratio_ff;
   logic [ROOT_W-1:0]   ratio_in;
   logic [FREQ_W-1:0]   open_freq;

   assign ratio_in = (CLAMP_W'(sqrt_root) < clamp_ff) ? sqrt_root
                                                      : ROOT_W'(clamp_ff);

   fpp_freq_mem #(
      .DEPTH (STRING_COUNT),
      .ADDR_W(ADDR_W)
   ) u_freq_mem (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (freq_wr_en),
      .wr_addr(ADDR_W'(freq_entry)),
      .wr_data(csr_data[FREQ_W-1:0]),
      .rd_en  (advance),
      .rd_addr(ADDR_W'(sqrt_tag.string_number)),
      .rd_data(open_freq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_tag_ff <= '0;
      end else if (advance) begin
         ratio_tag_ff <= sqrt_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ratio_ff <= ratio_in;
      end
   end

   // Multiply stage: open frequency times ratio; the ratio stays below
   // sqrt(10) * 2^16, so the scaled product always fits the pitch width
   stage_tag_type       mul_tag_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [FREQ_W-1:0]   open_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_tag_ff <= '0;
      end else if (advance) begin
         mul_tag_ff <= ratio_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= PROD_W'(open_freq) * PROD_W'(ratio_ff);
         open_ff <= open_freq;
      end
   end

   // Output register: select open, scaled or zero pitch
   logic [PITCH_W-1:0]  pitch_in;
   logic [PITCH_W-1:0]  pitch_ff;
   logic [1:0]          tag_ff;
   logic                open_string_ff;

   always_comb begin
      if (!mul_tag_ff.in_range) begin
         pitch_in = '0;
      end else if (mul_tag_ff.open_tail) begin
         pitch_in = PITCH_W'(open_ff);
      end else begin
         pitch_in = prod_ff[FRAC_BITS +: PITCH_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mul_tag_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pitch_ff       <= pitch_in;
         tag_ff         <= mul_tag_ff.string_number;
         open_string_ff <= mul_tag_ff.open_tail;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pitch_hz    = pitch_ff;
   assign rsp_string_tag  = tag_ff;
   assign rsp_open_string = open_string_ff;

endmodule

// ----- hdl/fpp_checker.sv -----
module fpp_checker
   import fpp_pkg::*;
#(
   parameter int STRING_COUNT = 4
) (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PITCH_W-1:0] rsp_pitch_hz,
   input logic [1:0]         rsp_string_tag,
   input logic               rsp_open_string
);

   // A waiting response word holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pitch_hz) &&
         $stable(rsp_string_tag) && $stable(rsp_open_string))
   else $error("response word changed while stalled");

   // Reset empties the response register
   assert property (@(posedge clock) reset |=> !rsp_valid)
   else $error("response valid after reset");

   // Requests are refused only while a response is held back
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
   else $error("request refused without a stalled response");

   // Strings beyond the configured count give zero pitch
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (int'(rsp_string_tag) >= STRING_COUNT) |-> rsp_pitch_hz == '0)
   else $error("non-zero pitch for a string beyond the count");

endmodule

bind fingerboard_position_to_pitch_core fpp_checker #(
   .STRING_COUNT(STRING_COUNT)
) u_fpp_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb
   import fpp_pkg::*;
();

   // Block shape and clocking
   localparam int STRINGS        = 4;
   localparam int SENSOR_BITS    = 12;
   localparam int FULL_SCALE     = (1 << SENSOR_BITS) - 1;
   localparam int TAIL_LIMIT     = FULL_SCALE * 20 / 200;
   localparam int MIN_PLAY_MM    = 30;
   localparam int CLK_HALF       = 6;
   localparam int RESET_CYCLES   = 7;
   localparam int PIPE_LATENCY   = 31;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_READINGS = 510;
   localparam int WATCHDOG_CYCLES = 400_000;

   // Register indexes past the end of the list: writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = CSR_INDEX_W'(CSR_OPEN_FREQ3) + 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = '1;

   typedef struct packed {
      logic [PITCH_W-1:0] pitch;
      logic [1:0]         tag;
      logic               open;
   } pitch_word_type;

   // One row of the opening plan: either a register write or a reading,
   // the latter with its result typed in where it is obvious
   typedef struct packed {
      logic                   csr_write;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
      logic [1:0]             string_number;
      logic [15:0]            reading;
      logic                   typed;
      pitch_word_type         known;
   } plan_row_type;

   localparam int PLAN_ROWS = 35;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_string_number = '0;
   logic [15:0]            req_sensor_reading = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [PITCH_W-1:0]     rsp_pitch_hz;
   logic [1:0]             rsp_string_tag;
   logic                   rsp_open_string;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Mirror of the block's registers
   logic [NECK_W-1:0] neck_mm;
   logic [FREQ_W-1:0] open_hz [STRINGS];

   pitch_word_type pitch_due [$];
   plan_row_type   opening_plan [PLAN_ROWS];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned readings_sent = 0;
   int unsigned open_readings = 0;
   int unsigned words_checked = 0;
   int unsigned writes_done   = 0;
   int unsigned fault_count   = 0;
   int unsigned hold_left     = 0;
   logic        pressure_armed = 1'b0;
   logic        hold_off_done  = 1'b0;

   fingerboard_position_to_pitch_core #(
      .STRING_COUNT(STRINGS),
      .SENSOR_BITS (SENSOR_BITS)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_string_number (req_string_number),
      .req_sensor_reading(req_sensor_reading),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pitch_hz      (rsp_pitch_hz),
      .rsp_string_tag    (rsp_string_tag),
      .rsp_open_string   (rsp_open_string),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Pitch for one reading under the current register mirror
   function automatic pitch_word_type pitch_for(input logic [1:0] sn, input logic [15:0] raw);
      logic [15:0] level;
      logic [63:0] quot;
      logic [63:0] root;
      logic [63:0] bitv;
      logic [63:0] clamp;
      logic [63:0] ratio;
      logic [63:0] product;
      pitch_word_type word;
      // saturate to full scale before any test
      level = (raw > FULL_SCALE) ? 16'(FULL_SCALE) : raw;
      word.tag  = sn;
      word.open = (level <= TAIL_LIMIT);
      if (sn >= STRINGS) begin
         product = '0;
      end else if (word.open) begin
         product = 64'(open_hz[sn]);
      end else begin
         // integer square root of FS * 2^32 / level, a bit pair at a time
         quot = (64'(FULL_SCALE) << 32) / 64'(level);
         root = '0;
         bitv = 64'h1 << 62;
         while (bitv > quot) bitv >>= 2;
         while (bitv != 0) begin
            if (quot >= root + bitv) begin
               quot -= root + bitv;
               root  = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         clamp   = (64'(neck_mm) << 16) / MIN_PLAY_MM;
         ratio   = (root < clamp) ? root : clamp;
         product = (64'(open_hz[sn]) * ratio) >> 16;
      end
      word.pitch = (product > 64'({PITCH_W{1'b1}})) ? {PITCH_W{1'b1}} : product[PITCH_W-1:0];
      return word;
   endfunction

   function automatic void note_register(input logic [CSR_INDEX_W-1:0] index,
                                         input logic [CSR_DATA_W-1:0]  data);
      case (index)
         CSR_NECK_LEN:   neck_mm    = data[NECK_W-1:0];
         CSR_OPEN_FREQ0: open_hz[0] = data[FREQ_W-1:0];
         CSR_OPEN_FREQ1: open_hz[1] = data[FREQ_W-1:0];
         CSR_OPEN_FREQ2: open_hz[2] = data[FREQ_W-1:0];
         CSR_OPEN_FREQ3: open_hz[3] = data[FREQ_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic plan_row_type plan_reading(input logic [1:0] sn, input logic [15:0] raw);
      plan_row_type row;
      row = '0;
      row.string_number = sn;
      row.reading       = raw;
      return row;
   endfunction

   function automatic plan_row_type plan_known(input logic [1:0] sn, input logic [15:0] raw,
                                               input logic [PITCH_W-1:0] pitch,
                                               input logic open);
      plan_row_type row;
      row = plan_reading(sn, raw);
      row.typed = 1'b1;
      row.known = '{pitch: pitch, tag: sn, open: open};
      return row;
   endfunction

   function automatic plan_row_type plan_write(input logic [CSR_INDEX_W-1:0] index,
                                               input logic [CSR_DATA_W-1:0]  data);
      plan_row_type row;
      row = '0;
      row.csr_write = 1'b1;
      row.index     = index;
      row.data      = data;
      return row;
   endfunction

   // Wait until every outstanding pitch word has come back
   task automatic drain_pitches();
      while (pitch_due.size() != 0) @(posedge clock);
   endtask

   // Write one register with nothing in flight, then drop valid again
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0]  data);
      // withdraw the last reading so it is not taken a second time
      req_valid <= 1'b0;
      drain_pitches();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      note_register(index, data);
      writes_done++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one reading, idling first at the sender's rate, and log its pitch on accept.
   // Valid is left high so that a back-to-back word follows without a gap.
   task automatic offer_reading(input logic [1:0] sn, input logic [15:0] raw,
                                input logic typed, input pitch_word_type known);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_string_number  <= sn;
      req_sensor_reading <= raw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pitch_due.push_back(typed ? known : pitch_for(sn, raw));
      readings_sent++;
      if (raw <= TAIL_LIMIT) open_readings++;
   endtask

   // Receiver: random back-pressure, plus one long hold-off once armed so the
   // pipeline fills and the block has to stall its input
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (pressure_armed && !hold_off_done) begin
         rsp_ready     <= 1'b0;
         hold_left     <= HOLD_OFF_CYCLES;
         hold_off_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each accepted pitch word with the oldest one outstanding
   always @(posedge clock) begin : check_pitch
      pitch_word_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (pitch_due.size() == 0) begin
            $error("unexpected rsp word: pitch_hz %0d string_tag %0d open_string %0d",
                   rsp_pitch_hz, rsp_string_tag, rsp_open_string);
            fault_count++;
         end else begin
            due = pitch_due.pop_front();
            if (rsp_pitch_hz !== due.pitch) begin
               $error("pitch_hz: expected %0d, actual %0d", due.pitch, rsp_pitch_hz);
               fault_count++;
            end
            if (rsp_string_tag !== due.tag) begin
               $error("string_tag: expected %0d, actual %0d", due.tag, rsp_string_tag);
               fault_count++;
            end
            if (rsp_open_string !== due.open) begin
               $error("open_string: expected %0d, actual %0d", due.open, rsp_open_string);
               fault_count++;
            end
         end
      end
   end

   initial begin : watchdog
      #(WATCHDOG_CYCLES * 2 * CLK_HALF);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : run
      logic [1:0]             sn;
      logic [15:0]            raw;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
      int unsigned            writes_due;

      neck_mm    = NECK_LEN_RESET;
      open_hz[0] = OPEN_FREQ0_RESET;
      open_hz[1] = OPEN_FREQ1_RESET;
      open_hz[2] = OPEN_FREQ2_RESET;
      open_hz[3] = OPEN_FREQ3_RESET;

      // Defaults first: open tail edges, full scale and saturation
      opening_plan[0]  = plan_known(2'd0, 16'd0, 22'd33536, 1'b1);
      opening_plan[1]  = plan_known(2'd3, 16'(TAIL_LIMIT), 22'd112640, 1'b1);
      opening_plan[2]  = plan_known(2'd1, 16'(FULL_SCALE), 22'd50176, 1'b0);
      opening_plan[3]  = plan_known(2'd2, 16'hFFFF, 22'd75008, 1'b0);
      opening_plan[4]  = plan_known(2'd3, 16'(FULL_SCALE + 1), 22'd112640, 1'b0);
      opening_plan[5]  = plan_reading(2'd0, 16'(TAIL_LIMIT + 1));
      opening_plan[6]  = plan_known(2'd1, 16'h8000, 22'd50176, 1'b0);
      opening_plan[7]  = plan_known(2'd2, 16'd1, 22'd75008, 1'b1);
      opening_plan[8]  = plan_reading(2'd3, 16'd2048);
      opening_plan[9]  = plan_reading(2'd2, 16'(TAIL_LIMIT + 2));
      // Zero neck length: silent above the tail, tail untouched
      opening_plan[10] = plan_write(CSR_NECK_LEN, 20'd0);
      opening_plan[11] = plan_known(2'd0, 16'(TAIL_LIMIT + 1), 22'd0, 1'b0);
      opening_plan[12] = plan_known(2'd1, 16'd200, 22'd50176, 1'b1);
      // Largest frequency and neck: the highest pitch the block can make
      opening_plan[13] = plan_write(CSR_OPEN_FREQ0, 20'hFFFFF);
      opening_plan[14] = plan_write(CSR_NECK_LEN, 20'd1023);
      opening_plan[15] = plan_known(2'd0, 16'(FULL_SCALE), 22'hFFFFF, 1'b0);
      opening_plan[16] = plan_reading(2'd0, 16'(TAIL_LIMIT + 1));
      opening_plan[17] = plan_reading(2'd0, 16'h5555);
      // Short neck: the clamp wins and halves the open frequency
      opening_plan[18] = plan_write(CSR_NECK_LEN, 20'd15);
      opening_plan[19] = plan_known(2'd2, 16'd3000, 22'd37504, 1'b0);
      opening_plan[20] = plan_write(CSR_OPEN_FREQ3, 20'd0);
      opening_plan[21] = plan_known(2'd3, 16'd1000, 22'd0, 1'b0);
      opening_plan[22] = plan_known(2'd3, 16'd5, 22'd0, 1'b1);
      // Writes past the register list, then a neck write with high bits to mask
      opening_plan[23] = plan_write(CSR_SPARE_FIRST, 20'hFFFFF);
      opening_plan[24] = plan_write(CSR_SPARE_LAST, 20'd0);
      opening_plan[25] = plan_write(CSR_NECK_LEN, 20'hFFC2D);
      opening_plan[26] = plan_known(2'd1, 16'(FULL_SCALE), 22'd50176, 1'b0);
      opening_plan[27] = plan_reading(2'd1, 16'd1000);
      opening_plan[28] = plan_write(CSR_OPEN_FREQ1, 20'd1);
      opening_plan[29] = plan_write(CSR_OPEN_FREQ2, 20'h80000);
      opening_plan[30] = plan_reading(2'd1, 16'(TAIL_LIMIT + 1));
      opening_plan[31] = plan_reading(2'd2, 16'd2500);
      opening_plan[32] = plan_reading(2'd2, 16'hFFFF);
      opening_plan[33] = plan_known(2'd0, 16'(FULL_SCALE), 22'hFFFFF, 1'b0);
      opening_plan[34] = plan_known(2'd3, 16'(FULL_SCALE), 22'd0, 1'b0);

      // Hold reset, then release it on an edge
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_plan[r]) begin
         if (opening_plan[r].csr_write)
            write_register(opening_plan[r].index, opening_plan[r].data);
         else
            offer_reading(opening_plan[r].string_number, opening_plan[r].reading,
                          opening_plan[r].typed, opening_plan[r].known);
      end

      // Random part: receiver-heavy idling, then sender-heavy, then none with the long hold-off armed
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 34;
               recv_idle_pct = 56;
            end
            1: begin
               send_idle_pct = 56;
               recv_idle_pct = 34;
            end
            default: begin
               send_idle_pct  = 0;
               recv_idle_pct  = 0;
               pressure_armed = 1'b1;
            end
         endcase
         writes_due = $urandom_range(120, 60);
         for (int n = 0; n < PHASE_READINGS; n++) begin
            // Every so often drain and retune a few registers, extremes included
            if (writes_due == 0) begin
               repeat ($urandom_range(3, 1)) begin
                  index = CSR_INDEX_W'($urandom_range(7, 0));
                  case ($urandom_range(5))
                     0:       data = '0;
                     1:       data = '1;
                     2:       data = CSR_DATA_W'($urandom_range(120));
                     default: data = CSR_DATA_W'($urandom);
                  endcase
                  write_register(index, data);
               end
               writes_due = $urandom_range(120, 60);
            end
            writes_due--;

            sn = 2'($urandom);
            case ($urandom_range(9))
               0, 1: raw = 16'($urandom);
               2:    raw = 16'($urandom_range(TAIL_LIMIT));
               3:    raw = 16'($urandom_range(TAIL_LIMIT + 12, TAIL_LIMIT - 8));
               4: begin
                  case ($urandom_range(5))
                     0:       raw = 16'd0;
                     1:       raw = 16'(TAIL_LIMIT);
                     2:       raw = 16'(TAIL_LIMIT + 1);
                     3:       raw = 16'(FULL_SCALE);
                     4:       raw = 16'(FULL_SCALE + 1);
                     default: raw = 16'hFFFF;
                  endcase
               end
               default: raw = 16'($urandom_range(FULL_SCALE, TAIL_LIMIT + 1));
            endcase
            offer_reading(sn, raw, 1'b0, '0);
         end
      end

      // Stop offering, let everything come back, then watch for stray words
      req_valid <= 1'b0;
      drain_pitches();
      repeat (2 * PIPE_LATENCY) @(posedge clock);

      $display("Sent %0d readings (%0d in the open tail), checked %0d pitch words,",
               readings_sent, open_readings, words_checked);
      $display("with %0d register writes, three idling mixes and one long output hold-off.",
               writes_done);
      if (fault_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
